### sv/eulr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eulr_pkg
// Shared constants and types for the Euler XYZ to rotation matrix block.
// ----------------------------------------------------------------------------
package eulr_pkg;

    localparam int PHASE_MUL    = 166886;
    localparam int CORDIC_STEPS = 18;
    localparam int XW           = 31;   // CORDIC datapath width (scale 2^28)
    localparam int RW           = 19;   // residual width
    localparam int SCW          = 18;   // sine/cosine width (scale 2^16)
    localparam logic signed [XW-1:0] CORDIC_X0 = 31'sd163008218;

    typedef logic signed [SCW-1:0] t_sc;

    typedef struct packed {
        t_sc s;
        t_sc c;
    } t_sincos;

    function automatic logic signed [RW-1:0] atan_tab(input int i);
        case (i)
            0:  atan_tab = 19'sd131072;
            1:  atan_tab = 19'sd77376;
            2:  atan_tab = 19'sd40884;
            3:  atan_tab = 19'sd20753;
            4:  atan_tab = 19'sd10417;
            5:  atan_tab = 19'sd5213;
            6:  atan_tab = 19'sd2607;
            7:  atan_tab = 19'sd1304;
            8:  atan_tab = 19'sd652;
            9:  atan_tab = 19'sd326;
            10: atan_tab = 19'sd163;
            11: atan_tab = 19'sd81;
            12: atan_tab = 19'sd41;
            13: atan_tab = 19'sd20;
            14: atan_tab = 19'sd10;
            15: atan_tab = 19'sd5;
            16: atan_tab = 19'sd3;
            default: atan_tab = 19'sd1;
        endcase
    endfunction

    // Round a scale-2^48 sum to Q1.14 (tie toward +inf) and saturate to +/-1.0.
    function automatic logic signed [15:0] to_q14(input logic signed [51:0] v);
        logic signed [51:0] t;
        logic signed [17:0] r;
        t = (v + 52'sd8589934592) >>> 34;
        r = t[17:0];
        if (r > 18'sd16384)       to_q14 = 16'sd16384;
        else if (r < -18'sd16384) to_q14 = -16'sd16384;
        else                      to_q14 = r[15:0];
    endfunction

endpackage

### sv/eulr_sincos_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eulr_sincos_lane
// Pipelined phase reduction and 18-stage CORDIC for one angle.
// ----------------------------------------------------------------------------
module eulr_sincos_lane import eulr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [15:0]  i_angle,
    output t_sincos             o_sc
);
    localparam int NS = CORDIC_STEPS;

    logic signed [35:0]   r_prod;
    logic [1:0]           r_q    [0:NS];
    logic signed [XW-1:0] r_x    [0:NS];
    logic signed [XW-1:0] r_y    [0:NS];
    logic signed [RW-1:0] r_r    [0:NS];
    t_sincos              r_sc;

    logic [19:0] w_phase;
    logic [19:0] w_ph2;
    logic signed [35:0] w_sum;
    assign w_sum   = r_prod + 36'sd2048;
    assign w_phase = w_sum[31:12];
    assign w_ph2   = w_phase + 20'h20000;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_angle * 36'(PHASE_MUL);
            r_q[0] <= w_ph2[19:18];
            r_r[0] <= $signed({1'b0, w_ph2[17:0]}) - 19'sd131072;
            r_x[0] <= CORDIC_X0;
            r_y[0] <= '0;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[i+1] <= r_q[i];
                if (!r_r[i][RW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_r[i+1] <= r_r[i] - atan_tab(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_r[i+1] <= r_r[i] + atan_tab(i);
                end
            end
        end
    end

    function automatic t_sc rnd(input logic signed [XW:0] v);
        logic signed [XW:0] t;
        t = (v + 32'sd2048) >>> 12;
        if (t > 32'sd65536)       rnd = 18'sd65536;
        else if (t < -32'sd65536) rnd = -18'sd65536;
        else                      rnd = t[SCW-1:0];
    endfunction

    logic signed [XW:0] w_xe, w_ye, w_c, w_s;
    assign w_xe = {r_x[NS][XW-1], r_x[NS]};
    assign w_ye = {r_y[NS][XW-1], r_y[NS]};

    always_comb begin
        case (r_q[NS])
            2'd0:    begin w_c = w_xe;  w_s = w_ye;  end
            2'd1:    begin w_c = -w_ye; w_s = w_xe;  end
            2'd2:    begin w_c = -w_xe; w_s = -w_ye; end
            default: begin w_c = w_ye;  w_s = -w_xe; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sc.c <= rnd(w_c);
            r_sc.s <= rnd(w_s);
        end
    end

    assign o_sc = r_sc;
endmodule

### sv/eulr_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eulr_merge
// Combine three sine/cosine pairs into the nine matrix entries.
// ----------------------------------------------------------------------------
module eulr_merge import eulr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_en,
    input  t_sincos       i_x,
    input  t_sincos       i_y,
    input  t_sincos       i_z,
    output logic [143:0]  o_rot
);
    // stage 1: pair products (scale 2^32)
    logic signed [35:0] r_cycz, r_cysz, r_cxsz, r_cxcz, r_sxcy;
    logic signed [35:0] r_sxsz, r_sxcz, r_cxcy, r_sxsy, r_cxsy;
    t_sc r_sy1, r_cz1, r_sz1;
    // stage 2: triple terms (scale 2^48)
    logic signed [51:0] r_t00, r_t01, r_t02, r_t12, r_t22;
    logic signed [51:0] r_a10, r_a11, r_a20, r_a21, r_b10, r_b11, r_b20, r_b21;
    logic [143:0] r_rot;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cycz <= i_y.c * i_z.c;  r_cysz <= i_y.c * i_z.s;
            r_cxsz <= i_x.c * i_z.s;  r_cxcz <= i_x.c * i_z.c;
            r_sxcy <= i_x.s * i_y.c;  r_sxsz <= i_x.s * i_z.s;
            r_sxcz <= i_x.s * i_z.c;  r_cxcy <= i_x.c * i_y.c;
            r_sxsy <= i_x.s * i_y.s;  r_cxsy <= i_x.c * i_y.s;
            r_sy1 <= i_y.s; r_cz1 <= i_z.c; r_sz1 <= i_z.s;

            r_t00 <= 52'(r_cycz) <<< 16;
            r_t01 <= -(52'(r_cysz) <<< 16);
            r_t02 <= 52'(r_sy1) <<< 32;
            r_t12 <= -(52'(r_sxcy) <<< 16);
            r_t22 <= 52'(r_cxcy) <<< 16;
            r_a10 <= 52'(r_cxsz) <<< 16;  r_b10 <= 52'(r_sxsy) * 52'(r_cz1);
            r_a11 <= 52'(r_cxcz) <<< 16;  r_b11 <= 52'(r_sxsy) * 52'(r_sz1);
            r_a20 <= 52'(r_sxsz) <<< 16;  r_b20 <= 52'(r_cxsy) * 52'(r_cz1);
            r_a21 <= 52'(r_sxcz) <<< 16;  r_b21 <= 52'(r_cxsy) * 52'(r_sz1);

            r_rot <= {to_q14(r_t22), to_q14(r_a21 + r_b21), to_q14(r_a20 - r_b20),
                      to_q14(r_t12), to_q14(r_a11 - r_b11), to_q14(r_a10 + r_b10),
                      to_q14(r_t02), to_q14(r_t01), to_q14(r_t00)};
        end
    end

    assign o_rot = r_rot;
endmodule

### sv/euler_xyz_to_rotation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_xyz_to_rotation
// XYZ Euler angles (Q3.12 rad) to rotation matrix R = Rx*Ry*Rz (Q1.14).
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one angle triple per transfer; master channel
//   carries the nine matrix entries of that triple, in order.
//   Three CORDIC lanes, one per axis, run side by side; a merge stage forms
//   products, rounds once and saturates each entry to +/-1.0.
//   Throughput: one triple every cycle while the receiver does not stall.
//   The whole pipeline advances as one; when the receiver stalls with a full
//   output register it holds, and s_axis_tready drops, so nothing is lost.
//   Reset clears the valid bits of every stage; payload is not cleared.
// ----------------------------------------------------------------------------
module euler_xyz_to_rotation import eulr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [47:0]   s_axis_tdata,   // angle_x, angle_y, angle_z
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [143:0]  m_axis_tdata    // rot_00, rot_01, ..., rot_22
);
    localparam int LAT = 24;

    logic [LAT-1:0] r_vld;
    logic w_en;
    t_sincos w_x, w_y, w_z;

    // advance whenever the last stage is empty or being drained
    assign w_en          = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    eulr_sincos_lane u_lane_x (.i_clk, .i_en(w_en),
        .i_angle(s_axis_tdata[15:0]),  .o_sc(w_x));
    eulr_sincos_lane u_lane_y (.i_clk, .i_en(w_en),
        .i_angle(s_axis_tdata[31:16]), .o_sc(w_y));
    eulr_sincos_lane u_lane_z (.i_clk, .i_en(w_en),
        .i_angle(s_axis_tdata[47:32]), .o_sc(w_z));

    eulr_merge u_merge (.i_clk, .i_en(w_en), .i_x(w_x), .i_y(w_y), .i_z(w_z),
        .o_rot(m_axis_tdata));
endmodule

### sv/eulr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eulr_checker
// Port-level checks for the rotation block.
// ----------------------------------------------------------------------------
module eulr_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [143:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output changed");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_rdy2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("valid after reset");
endmodule

bind euler_xyz_to_rotation eulr_checker u_chk (.i_clk, .i_rst_n, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata);

### tb/sv/euler_xyz_to_rotation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_xyz_to_rotation_tb
// Drives angle triples into the rotation matrix block and checks each of the
// nine Q1.14 entries against a fixed-point CORDIC predictor held here, under
// random sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module euler_xyz_to_rotation_tb;
    import eulr_pkg::*;

    typedef struct {
        logic signed [15:0] ent [9];
    } t_matrix;

    // Scoreboard: predicts the matrix of each accepted triple and compares
    // results against the oldest prediction.
    class rot_scoreboard;
        t_matrix pending [$];
        int      n_fail;
        int      n_checked;

        function automatic longint fshr(input longint v, input int s);
            return v >>> s;  // arithmetic shift on a signed longint floors
        endfunction

        function automatic longint clampv(input longint v, input longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        // Sine and cosine at scale 2^16 from a Q3.12 angle.
        function automatic void trig(input logic signed [15:0] ang,
                                     output longint s_o, output longint c_o);
            longint prod, xv, yv, dx, dy, cc, ss, rr;
            logic [19:0] ph;
            logic [19:0] phq;
            int quad;
            int steps [18];
            steps = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                      652, 326, 163, 81, 41, 20, 10, 5, 3, 1};
            prod = longint'(ang) * 166886;
            ph = 20'((prod + 2048) >>> 12);
            phq = ph + 20'h20000;
            quad = int'(phq[19:18]);
            rr = longint'({1'b0, phq[17:0]}) - 131072;
            xv = 163008218;
            yv = 0;
            for (int i = 0; i < 18; i++) begin
                dx = fshr(yv, i);
                dy = fshr(xv, i);
                if (rr >= 0) begin
                    xv -= dx; yv += dy; rr -= steps[i];
                end else begin
                    xv += dx; yv -= dy; rr += steps[i];
                end
            end
            case (quad)
                0: begin cc = xv;  ss = yv;  end
                1: begin cc = -yv; ss = xv;  end
                2: begin cc = -xv; ss = -yv; end
                default: begin cc = yv; ss = -xv; end
            endcase
            c_o = clampv(fshr(cc + 2048, 12), 65536);
            s_o = clampv(fshr(ss + 2048, 12), 65536);
        endfunction

        function automatic logic signed [15:0] q14(input longint v48);
            return 16'(clampv(fshr(v48 + (64'sd1 <<< 33), 34), 16384));
        endfunction

        // Note an accepted triple and queue its expected matrix.
        function void note_triple(input logic [47:0] angles);
            longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
            longint one = 65536;
            t_matrix m;
            trig(angles[15:0], sx, cx);
            trig(angles[31:16], sy, cy);
            trig(angles[47:32], sz, cz);
            sxsy = sx * sy;
            cxsy = cx * sy;
            m.ent[0] = q14(cy * cz * one);
            m.ent[1] = q14(-cy * sz * one);
            m.ent[2] = q14(sy * one * one);
            m.ent[3] = q14(cx * sz * one + sxsy * cz);
            m.ent[4] = q14(cx * cz * one - sxsy * sz);
            m.ent[5] = q14(-sx * cy * one);
            m.ent[6] = q14(sx * sz * one - cxsy * cz);
            m.ent[7] = q14(sx * cz * one + cxsy * sz);
            m.ent[8] = q14(cx * cy * one);
            pending.push_back(m);
        endfunction

        function void check_matrix(input logic [143:0] got);
            t_matrix m;
            logic signed [15:0] act;
            if (pending.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) $display("unexpected result %h", got);
                return;
            end
            m = pending.pop_front();
            n_checked++;
            for (int k = 0; k < 9; k++) begin
                act = got[16*k +: 16];
                if (act !== m.ent[k]) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("entry %0d of result %0d: expected %0d, got %0d",
                                 k, n_checked, m.ent[k], act);
                end
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata;   // angle_x, angle_y, angle_z
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;   // rot_00 .. rot_22

    rot_scoreboard rot_sb;
    logic [47:0]   triple_q [$];
    int            hold_off;      // receiver hold-off left, in cycles

    euler_xyz_to_rotation dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Limit: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("euler_xyz_to_rotation_tb: FAIL");
        $finish;
    end

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 51472)) - 25736); // within +/-2pi
            2: return 16'($signed($urandom_range(0, 1000)) - 500);   // near zero
            default: begin
                // near a quarter-turn multiple, where quadrant boundaries sit
                int base;
                base = 6434 * $signed($urandom_range(0, 10)) - 32170;
                return 16'(base + $signed($urandom_range(0, 8)) - 4);
            end
        endcase
    endfunction

    // Offer one triple at the falling edge and hold it until accepted.
    task automatic send_triple(input logic [47:0] t);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_gap(input int n);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Input monitor: note every accepted triple.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            rot_sb.note_triple(s_axis_tdata);
    end

    // Output monitor: check every accepted matrix.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            rot_sb.check_matrix(m_axis_tdata);
    end

    // Receiver: stall on its own pattern, with calm stretches and one long hold.
    initial begin
        int mode;
        m_axis_tready = 1'b0;
        mode = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                hold_off--;
                m_axis_tready <= 1'b0;
            end else begin
                if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        int axes [4];
        int burst;
        int waited;
        rot_sb = new();
        hold_off = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, zero, quarter turns and wrap beyond 2pi.
        axes = '{0, 6434, 12868, -6434};
        triple_q.push_back('0);
        triple_q.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF});
        triple_q.push_back({16'h8000, 16'h8000, 16'h8000});
        triple_q.push_back({16'h8000, 16'h7FFF, 16'hFFFF});
        triple_q.push_back({16'h0001, 16'hFFFF, 16'h5555});
        triple_q.push_back({16'hAAAA, 16'h5555, 16'hAAAA});
        triple_q.push_back({16'd25736, 16'd25736, 16'd25736});
        triple_q.push_back({16'd30000, -16'sd30000, 16'd27000});
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                triple_q.push_back({16'(axes[j]), 16'(axes[i]), 16'(axes[(i+j)%4])});
        while (triple_q.size() > 0) send_triple(triple_q.pop_front());
        send_gap(1);

        // Long hold-off while the sender keeps offering, to fill the pipeline.
        hold_off = 120;
        for (int i = 0; i < 60; i++)
            send_triple({rand_angle(), rand_angle(), rand_angle()});

        // Random bursts with gaps.
        for (int n = 0; n < 540; ) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst; b++) begin
                send_triple({rand_angle(), rand_angle(), rand_angle()});
                n++;
            end
            if ($urandom_range(0, 2) != 0) send_gap($urandom_range(1, 8));
        end
        send_gap(1);

        waited = 0;
        while (rot_sb.pending.size() > 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);

        $display("covered %0d matrices: extreme and wrapping angles, quarter turns,",
                 rot_sb.n_checked);
        $display("random bursts, receiver stalls and a long output hold-off");
        if (rot_sb.n_fail == 0 && rot_sb.pending.size() == 0) begin
            $display("euler_xyz_to_rotation_tb: PASS");
        end else begin
            $display("mismatches: %0d, missing results: %0d",
                     rot_sb.n_fail, rot_sb.pending.size());
            $display("euler_xyz_to_rotation_tb: FAIL");
        end
        $finish;
    end

endmodule
